@@ src/lce_pkg.sv @@
package lce_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_TAPS_DEF     = 16;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int SUM_W     = 36;
  localparam int SUM_BUS_W = ((SUM_W + 7) / 8) * 8;
  localparam int CIDX_W    = 4;
  localparam int CIDX_N    = 1 << CIDX_W;
  localparam int TAP_CNT_W = 5;

  // Register file
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic                 REG_TAP_COUNT = 1'b0;
  localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST = 5'd3;

  // Request kinds carried on tuser
  localparam logic KIND_COEF   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DONE
  } lce_state_e;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;  // zero the accumulator and flush the product stage
    logic en;     // operands at the inputs belong to a live tap
  } lce_mac_ctl_t;

endpackage

@@ src/lce_ram.sv @@
module lce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/lce_mac.sv @@
module lce_mac
  import lce_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lce_mac_ctl_t                   ctl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] coef_i,
  input  logic signed [SAMPLE_WIDTH-1:0] samp_i,
  output logic signed [SUM_W-1:0]        acc_o
);

  logic signed [2*SAMPLE_WIDTH-1:0] prod_full;
  logic signed [SUM_W-1:0]          prod_q;
  logic                             pen_q;
  logic signed [SUM_W-1:0]          acc_q;

  assign prod_full = coef_i * samp_i;

  // product stage, then accumulate (sum wraps at SUM_W bits)
  always_ff @(posedge clk_i) begin
    prod_q <= SUM_W'(prod_full);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q <= 1'b0;
      acc_q <= '0;
    end else if (ctl_i.clear) begin
      pen_q <= 1'b0;
      acc_q <= '0;
    end else begin
      pen_q <= ctl_i.en;
      if (pen_q) begin
        acc_q <= acc_q + prod_q;
      end
    end
  end

  assign acc_o = acc_q;

endmodule

@@ src/linear_convolution_engine.sv @@
// Direct-form FIR engine giving the full linear convolution of a sample block
// with an impulse response of tap_count taps (0 counts as 1, above MAX_TAPS
// saturates). A request with tuser = 0 writes one coefficient at coef_index
// (wrapped to the store) and gives no result; a request with tuser = 1 is a
// sample and gives one 36-bit result y[n]. A sample with tlast set also
// flushes tap_count-1 tail results with zeros shifted in; the final result of
// the block carries tlast and the sample history is cleared after it. One
// shared multiplier and accumulator walks every tap slot in turn while the
// history rotates past it, so a sample is accepted, its tap slots are walked,
// the products pass the coefficient read and product registers and the sum is
// loaded into the output register; each tail result repeats the walk. A
// coefficient write completes on acceptance. No request is taken while a sum is in
// progress, but a finished result waiting on m_axis_tready does not block a
// new request. Reset clears the coefficients (per-entry valid bits), the
// history and sets tap_count to 3. No clearing pass is needed after reset.
module linear_convolution_engine
  import lce_pkg::*;
#(
  parameter int MAX_TAPS     = MAX_TAPS_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // coef_index, data_value, zero padding
  input  logic [((CIDX_W+SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic                  s_axis_tuser,  // kind
  input  logic                  s_axis_tlast,  // end_of_block
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [SUM_BUS_W-1:0]  m_axis_tdata,  // sum_value, zero padding
  output logic                  m_axis_tlast   // last_result
);

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW = $clog2(MAX_TAPS + 2);
  localparam int MW = $clog2(MAX_TAPS + 1);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [TAP_CNT_W-1:0] tap_count_q;
  logic                 cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_TAP_COUNT);
  assign prdata = (paddr[2] == REG_TAP_COUNT) ? APB_DATA_W'(tap_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_COUNT_RST;
    end else if (cfg_we) begin
      tap_count_q <= pwdata[TAP_CNT_W-1:0];
    end
  end

  // taps in use: zero counts as one, saturate at the store size
  logic [MW-1:0] m_eff;
  always_comb begin
    if (tap_count_q == '0) begin
      m_eff = MW'(1);
    end else if (32'(tap_count_q) > MAX_TAPS) begin
      m_eff = MW'(MAX_TAPS);
    end else begin
      m_eff = MW'(tap_count_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Request fields
  // ---------------------------------------------------------------------------
  logic [CIDX_W-1:0]              in_cidx;
  logic signed [SAMPLE_WIDTH-1:0] in_data;
  logic                           in_acc;

  assign in_cidx = s_axis_tdata[CIDX_W-1:0];
  assign in_data = s_axis_tdata[CIDX_W +: SAMPLE_WIDTH];
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  // coefficient index wrapped to the store, worked out at elaboration
  logic [AW-1:0] wrap_lut [CIDX_N];
  for (genvar g = 0; g < CIDX_N; g++) begin : g_wrap
    assign wrap_lut[g] = AW'(g % MAX_TAPS);
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  lce_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [MW-1:0] rem_q, rem_d;   // tail results still owed after this one
  logic          eob_q, eob_d;
  logic          issue;          // a tap slot is presented this cycle
  logic          load;           // accumulator moves to the output register
  logic          coef_we;
  logic          samp_in;        // real sample enters the history
  logic          zero_in;        // flush zero enters the history
  logic          hist_clr;
  lce_mac_ctl_t  mac_ctl;
  logic          tap_en_q, tap_en_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_axis_tuser == KIND_SAMPLE)) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (32'(cnt_q) == MAX_TAPS + 1) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_d = (rem_q != '0) ? ST_MAC : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    issue         = (state_q == ST_MAC) && (32'(cnt_q) < MAX_TAPS);
    load          = (state_q == ST_DONE) && (!m_axis_tvalid || m_axis_tready);
    coef_we       = in_acc && (s_axis_tuser == KIND_COEF);
    samp_in       = in_acc && (s_axis_tuser == KIND_SAMPLE);
    zero_in       = load && (rem_q != '0);
    hist_clr      = load && (rem_q == '0) && eob_q;
    mac_ctl.clear = samp_in || zero_in;
    mac_ctl.en    = tap_en_q;

    cnt_d = cnt_q;
    rem_d = rem_q;
    eob_d = eob_q;
    if (samp_in) begin
      cnt_d = '0;
      eob_d = s_axis_tlast;
      rem_d = s_axis_tlast ? (m_eff - MW'(1)) : '0;
    end else if (state_q == ST_MAC) begin
      cnt_d = cnt_q + CW'(1);
    end else if (zero_in) begin
      cnt_d = '0;
      rem_d = rem_q - MW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Coefficient store: RAM plus a valid bit per entry (unwritten reads zero)
  // ---------------------------------------------------------------------------
  logic [MAX_TAPS-1:0]     cvalid_q;
  logic [SAMPLE_WIDTH-1:0] coef_rdata;
  logic [AW-1:0]           rd_addr;

  assign rd_addr = cnt_q[AW-1:0];

  lce_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (wrap_lut[in_cidx]),
    .wdata_i (in_data),
    .raddr_i (rd_addr),
    .rdata_o (coef_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvalid_q <= '0;
    end else if (coef_we) begin
      cvalid_q[wrap_lut[in_cidx]] <= 1'b1;
    end
  end

  // slot k contributes only for k < m and a written coefficient
  assign tap_en_d = issue && (32'(cnt_q) < 32'(m_eff)) && cvalid_q[rd_addr];

  // ---------------------------------------------------------------------------
  // Sample history: newest at slot 0, rotated once per tap slot so the
  // multiplier always reads slot 0; MAX_TAPS rotations restore the order.
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_WIDTH-1:0] hist_q [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] hist_d [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] samp_q;

  always_comb begin
    for (int i = 0; i < MAX_TAPS; i++) begin
      hist_d[i] = hist_q[i];
    end
    if (samp_in || zero_in) begin
      hist_d[0] = samp_in ? in_data : '0;
      for (int i = 1; i < MAX_TAPS; i++) begin
        hist_d[i] = hist_q[i-1];
      end
    end else if (issue) begin
      for (int i = 0; i < MAX_TAPS - 1; i++) begin
        hist_d[i] = hist_q[i+1];
      end
      hist_d[MAX_TAPS-1] = hist_q[0];
    end else if (hist_clr) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        hist_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        hist_q[i] <= hist_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q <= hist_q[0];
  end

  // ---------------------------------------------------------------------------
  // Shared multiply-accumulate
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] acc;

  lce_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .coef_i (coef_rdata),
    .samp_i (samp_q),
    .acc_o  (acc)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic                    out_valid_q;
  logic [SUM_W-1:0]        out_sum_q;
  logic                    out_last_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_sum_q  <= acc;
      out_last_q <= eob_q && (rem_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rem_q       <= '0;
      eob_q       <= 1'b0;
      tap_en_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      eob_q    <= eob_d;
      tap_en_q <= tap_en_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = SUM_BUS_W'(out_sum_q);
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // tail results are owed only within a marked block
  a_rem_needs_eob: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != '0) |-> eob_q)
    else $error("tail count set outside a marked block");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_q || m_axis_tready))
    else $error("result register overwritten");

  // the final result of a block leaves an empty history behind
  a_hist_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_clr |=> (hist_q[0] == '0) && (hist_q[MAX_TAPS-1] == '0))
    else $error("history not cleared after block");

  // no tap is fed to the multiplier outside the tap slots
  a_tap_in_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tap_en_q |-> $past(issue))
    else $error("tap enable outside a tap slot");

  // the sequencer moves from the tap walk to the done state once the pipeline is drained
  a_done_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) && (32'(cnt_q) == MAX_TAPS + 1) |=> (state_q == ST_DONE))
    else $error("sequencer left the tap walk early or late");
`endif

endmodule
